// ===== rtl/core/pse_pkg.sv =====
// Shared types, constants and saturation helpers for the polynomial series
// evaluator. No dependencies; imported by the core, pse_term and the testbench.
package pse_pkg;

  // Default configuration
  localparam int NUM_COEFFS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 24;

  // Fixed field widths
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 2;
  localparam int INDEX_W   = 4;
  localparam int S_TDATA_W = 72;
  localparam int M_TUSER_W = 2;
  localparam int CFG_IDX_W = 2;
  // Term scale factor reaches NUM_COEFFS, at most 127
  localparam int FACT_W    = 7;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  // Item kinds carried in tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SERIES = 2'd1,
    MODE_DERIV  = 2'd2,
    MODE_INTEG  = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXP_POINT  = 2'd0,
    REG_RANGE_LOW  = 2'd1,
    REG_RANGE_HIGH = 2'd2
  } cfg_reg_t;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // One term request handed to the term unit
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              zero;   // constant zero term, no coefficient behind it
    logic              live;   // coefficient entry was written since reset
    mode_t             mode;
    logic [FACT_W-1:0] factor; // multiplier (derivative) or divisor (integral)
  } issue_t;

  // One finished term
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     sat;
    logic signed [DATA_W-1:0] term;
  } term_beat_t;

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > MAX32) || (v < MIN32);
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = v;
    if (v > MAX32) c = MAX32;
    if (v < MIN32) c = MIN32;
    return c[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/core/polynomial_series_evaluator_core.sv =====
// Horner power-series evaluator, signed fixed point. Depends on pse_pkg,
// pse_ram and pse_term.
// A load item writes the store and gives no result beat. An evaluation runs
// T terms (series 12, derivative 11, integral 13) before its result beat;
// out-of-range x skips the terms. Loads are taken every cycle while idle; no item is
// taken while an evaluation runs or its result waits. Each Horner step is a multiply, then round/add.
// Reset: registers to defaults, coefficient valid bits cleared (store reads 0).
module polynomial_series_evaluator_core
  import pse_pkg::*;
#(
  parameter int NUM_COEFFS = NUM_COEFFS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // coeff_index[3:0], coeff_value[35:4], x_value[67:36]
  input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // value[31:0]
  output logic [M_TUSER_W-1:0] m_tuser,   // out_of_range[0], saturated[1]
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(NUM_COEFFS);
  localparam int K_W    = $clog2(NUM_COEFFS + 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // Input beat fields
  mode_t                    in_mode;
  logic [INDEX_W-1:0]       in_index;
  logic signed [DATA_W-1:0] in_coeff;
  logic signed [DATA_W-1:0] in_x;

  assign in_mode  = mode_t'(s_tuser);
  assign in_index = s_tdata[3:0];
  assign in_coeff = $signed(s_tdata[35:4]);
  assign in_x     = $signed(s_tdata[67:36]);

  // Configuration registers
  logic signed [DATA_W-1:0] exp_point;
  logic signed [DATA_W-1:0] range_low;
  logic signed [DATA_W-1:0] range_high;

  state_t state, state_next;

  logic                     accept;
  logic                     is_eval;
  logic                     in_range;
  logic                     load_we;
  logic [ADDR_W-1:0]        load_addr;
  logic                     out_free;
  logic                     out_load;
  logic                     issue_now;

  logic [NUM_COEFFS-1:0]    vld;
  logic                     issuing;
  logic                     phase;
  logic                     first;
  logic [K_W-1:0]           k;
  mode_t                    eval_mode;
  logic signed [DATA_W-1:0] t;
  logic signed [DATA_W-1:0] acc;
  logic signed [63:0]       prod;
  logic                     sat;
  logic                     oor;

  issue_t                   issue;
  term_beat_t               beat;
  logic [ADDR_W-1:0]        raddr;
  logic [DATA_W-1:0]        rdata;

  assign cfg_ready = 1'b1;

  assign accept    = s_tvalid && s_tready;
  assign is_eval   = in_mode != MODE_LOAD;
  assign in_range  = !((in_x < range_low) || (in_x > range_high));
  assign load_we   = accept && !is_eval && (32'(in_index) < NUM_COEFFS);
  assign load_addr = ADDR_W'(in_index);
  assign out_free  = !m_tvalid || m_tready;

  // Offset from the expansion point
  logic signed [63:0] t_wide;
  assign t_wide = 64'(in_x) - 64'(exp_point);

  // Terms in the evaluation, less one
  logic [K_W-1:0] k_start;
  always_comb begin
    case (in_mode)
      MODE_DERIV: k_start = K_W'(NUM_COEFFS - 2);
      MODE_INTEG: k_start = K_W'(NUM_COEFFS);
      default:    k_start = K_W'(NUM_COEFFS - 1);
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_eval) begin
          state_next = in_range ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (beat.valid && beat.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready  = 1'b0;
    out_load  = 1'b0;
    issue_now = 1'b0;
    case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_RUN:  issue_now = issuing && !phase;
      ST_DONE: out_load  = out_free;
      default: s_tready  = 1'b0;
    endcase
  end

  // Term request from the countdown: coefficient address and factor
  always_comb begin
    issue.valid = issue_now;
    issue.last  = (k == '0);
    issue.zero  = 1'b0;
    issue.mode  = eval_mode;
    case (eval_mode)
      MODE_DERIV: begin
        raddr        = ADDR_W'(32'(k) + 32'd1);
        issue.factor = FACT_W'(32'(k) + 32'd1);
      end
      MODE_INTEG: begin
        raddr        = (k == '0) ? '0 : ADDR_W'(32'(k) - 32'd1);
        issue.factor = FACT_W'(k);
        issue.zero   = (k == '0);
      end
      default: begin
        raddr        = ADDR_W'(k);
        issue.factor = FACT_W'(1);
      end
    endcase
    issue.live = vld[raddr] && !issue.zero;
  end

  pse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_COEFFS)
  ) u_coef_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_addr),
    .wdata(in_coeff),
    .raddr(raddr),
    .rdata(rdata)
  );

  pse_term #(
    .NUM_COEFFS(NUM_COEFFS)
  ) u_term (
    .clk  (clk),
    .rst  (rst),
    .issue(issue),
    .rdata(rdata),
    .beat (beat)
  );

  // Horner step: rounded product of last accumulator plus the new term
  logic signed [63:0] h_sum;
  assign h_sum = ((prod + HALF) >>> FRAC_BITS) + 64'(beat.term);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      exp_point  <= '0;
      range_low  <= 32'sh8000_0000;
      range_high <= 32'sh7FFF_FFFF;
      vld        <= '0;
      issuing    <= 1'b0;
      phase      <= 1'b0;
      first      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_EXP_POINT:  exp_point  <= $signed(cfg_data);
          REG_RANGE_LOW:  range_low  <= $signed(cfg_data);
          REG_RANGE_HIGH: range_high <= $signed(cfg_data);
          default: ;
        endcase
      end

      if (load_we) begin
        vld[load_addr] <= 1'b1;
      end

      // Term issue, paced by the phase bit
      if (accept && is_eval && in_range) begin
        issuing <= 1'b1;
        phase   <= 1'b0;
        first   <= 1'b1;
      end else begin
        if (issuing) begin
          phase <= !phase;
        end
        if (issue_now && (k == '0)) begin
          issuing <= 1'b0;
        end
        if (beat.valid) begin
          first <= 1'b0;
        end
      end

      // Result register
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= acc * t;

    if (accept && is_eval) begin
      eval_mode <= in_mode;
      k         <= k_start;
      t         <= clamp32(t_wide);
      if (in_range) begin
        sat <= ovf32(t_wide);
        oor <= 1'b0;
      end else begin
        acc <= '0;
        sat <= 1'b0;
        oor <= 1'b1;
      end
    end else begin
      if (issue_now && (k != '0)) begin
        k <= k - K_W'(1);
      end
      if (beat.valid) begin
        if (first) begin
          acc <= beat.term;
          sat <= sat || beat.sat;
        end else begin
          acc <= clamp32(h_sum);
          sat <= sat || beat.sat || ovf32(h_sum);
        end
      end
    end

    if (out_load) begin
      m_tdata <= acc;
      m_tuser <= {sat, oor};
    end
  end

endmodule

// ===== rtl/core/pse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pse_term.sv =====
// Term unit: turns coefficient read data into series, derivative or
// integral terms, five register stages. Depends on pse_pkg.
module pse_term
  import pse_pkg::*;
#(
  parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  issue_t            issue,
  input  logic [DATA_W-1:0] rdata,
  output term_beat_t        beat
);

  localparam int RIDX_W = $clog2(NUM_COEFFS + 1);

  // Reciprocal table floor((2^32-1)/i), entry 0 unused
  logic [31:0] recip [NUM_COEFFS+1];
  for (genvar g = 0; g <= NUM_COEFFS; g++) begin : g_rcp
    localparam longint unsigned RCP = 64'hFFFF_FFFF / ((g == 0) ? 1 : g);
    assign recip[g] = RCP[31:0];
  end

  issue_t s1, s2, s3, s4;

  // Stage 1: coefficient in, scale multiply and magnitude for division
  logic signed [DATA_W-1:0] coef;
  logic                     neg1;
  logic [DATA_W-1:0]        mag1;
  logic [DATA_W-1:0]        n1;
  logic signed [39:0]       prod1;

  assign coef  = s1.live ? $signed(rdata) : '0;
  assign neg1  = coef[DATA_W-1];
  assign mag1  = neg1 ? (32'd0 - $unsigned(coef)) : $unsigned(coef);
  assign n1    = mag1 + 32'(s1.factor >> 1);
  assign prod1 = coef * $signed({1'b0, s1.factor});

  logic signed [39:0] s2_prod;
  logic [DATA_W-1:0]  s2_n;
  logic               s2_neg;

  // Stage 2: reciprocal multiply, clamp of the scaled term
  logic [63:0] big2;
  assign big2 = 64'(s2_n) * 64'(recip[s2.factor[RIDX_W-1:0]]);

  logic [DATA_W-1:0]        s3_q0;
  logic [DATA_W-1:0]        s3_n;
  logic                     s3_neg;
  logic signed [DATA_W-1:0] s3_term;
  logic                     s3_sat;

  // Stage 3: back-multiply the quotient estimate
  logic [38:0] qi3;
  assign qi3 = 39'(s3_q0) * 39'(s3.factor);

  logic [DATA_W-1:0]        s4_q0;
  logic [DATA_W-1:0]        s4_n;
  logic [38:0]              s4_qi;
  logic                     s4_neg;
  logic signed [DATA_W-1:0] s4_term;
  logic                     s4_sat;

  // Stage 4: one correction step, sign restore, term select
  logic [38:0]              rem4;
  logic                     inc4;
  logic [32:0]              q4;
  logic [32:0]              qs4;
  logic signed [DATA_W-1:0] term4;

  assign rem4 = 39'(s4_n) - s4_qi;
  assign inc4 = rem4 >= 39'(s4.factor);
  assign q4   = 33'(s4_q0) + 33'(inc4);
  assign qs4  = s4_neg ? (33'd0 - q4) : q4;

  always_comb begin
    if (s4.zero) begin
      term4 = '0;
    end else if (s4.mode == MODE_INTEG) begin
      term4 = $signed(qs4[DATA_W-1:0]);
    end else begin
      term4 = s4_term;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid   <= 1'b0;
      s2.valid   <= 1'b0;
      s3.valid   <= 1'b0;
      s4.valid   <= 1'b0;
      beat.valid <= 1'b0;
    end else begin
      s1.valid   <= issue.valid;
      s2.valid   <= s1.valid;
      s3.valid   <= s2.valid;
      s4.valid   <= s3.valid;
      beat.valid <= s4.valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    {s1.last, s1.zero, s1.live, s1.mode, s1.factor} <=
      {issue.last, issue.zero, issue.live, issue.mode, issue.factor};
    {s2.last, s2.zero, s2.live, s2.mode, s2.factor} <=
      {s1.last, s1.zero, s1.live, s1.mode, s1.factor};
    {s3.last, s3.zero, s3.live, s3.mode, s3.factor} <=
      {s2.last, s2.zero, s2.live, s2.mode, s2.factor};
    {s4.last, s4.zero, s4.live, s4.mode, s4.factor} <=
      {s3.last, s3.zero, s3.live, s3.mode, s3.factor};

    s2_prod <= prod1;
    s2_n    <= n1;
    s2_neg  <= neg1;

    s3_q0   <= big2[63:32];
    s3_n    <= s2_n;
    s3_neg  <= s2_neg;
    s3_term <= clamp32(64'(s2_prod));
    s3_sat  <= (s2.mode == MODE_DERIV) && ovf32(64'(s2_prod));

    s4_q0   <= s3_q0;
    s4_n    <= s3_n;
    s4_qi   <= qi3;
    s4_neg  <= s3_neg;
    s4_term <= s3_term;
    s4_sat  <= s3_sat;

    beat.last <= s4.last;
    beat.sat  <= s4_sat && !s4.zero && (s4.mode == MODE_DERIV);
    beat.term <= term4;
  end

endmodule

// ===== tb/sv/polynomial_series_evaluator_core_tb.sv =====
// Self-checking testbench for polynomial_series_evaluator_core: a directed table of
// beats, then random load/evaluate traffic checked against an in-bench fixed point
// series predictor. Depends on pse_pkg and the core RTL only.
module polynomial_series_evaluator_core_tb;
  import pse_pkg::*;

  localparam int NCOEF = NUM_COEFFS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  // Longest evaluation (integral) plus margin
  localparam int LAT = 2 * (NCOEF + 1) + 6 + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;
  localparam int NUM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam logic [31:0] W_MAX = 32'h7fff_ffff;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0100_0000;
  localparam longint L_MAX = 64'sd2147483647;
  localparam longint L_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    logic oor;
    logic sat;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    mode_t mode;
    logic [INDEX_W-1:0] idx;
    logic [CFG_IDX_W-1:0] sel;
    logic [31:0] a;      // coefficient, or register data
    logic [31:0] b;      // x
    logic fixed;         // typed-in expectation below
    outcome_t want;
  } row_t;

  localparam outcome_t NONE = '0;
  localparam outcome_t ZERO = '{32'sh0, 1'b0, 1'b0};
  localparam outcome_t OUT_RANGE = '{32'sh0, 1'b1, 1'b0};
  localparam outcome_t UNIT = '{32'sh0100_0000, 1'b0, 1'b0};

  // Directed table: empty store, ignored loads, extremes, range checks, bad reg index
  localparam int NDIR = 26;
  localparam row_t DIRECTED [NDIR] = '{
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, 32'h0,        1'b1, ZERO},
    '{ROW_ITEM, MODE_DERIV,  4'd0,  REG_EXP_POINT,  32'h0, W_MAX,        1'b1, ZERO},
    '{ROW_ITEM, MODE_INTEG,  4'd0,  REG_EXP_POINT,  32'h0, W_MIN,        1'b1, ZERO},
    '{ROW_ITEM, MODE_LOAD,   4'd15, REG_EXP_POINT,  W_MAX, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_LOAD,   4'd12, REG_EXP_POINT,  W_MIN, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, Q_ONE,        1'b1, ZERO},
    '{ROW_ITEM, MODE_LOAD,   4'd0,  REG_EXP_POINT,  Q_ONE, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, W_MAX,        1'b1, UNIT},
    '{ROW_ITEM, MODE_LOAD,   4'd11, REG_EXP_POINT,  W_MAX, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_LOAD,   4'd1,  REG_EXP_POINT,  W_MIN, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, W_MAX,        1'b0, NONE},
    '{ROW_ITEM, MODE_DERIV,  4'd0,  REG_EXP_POINT,  32'h0, W_MIN,        1'b0, NONE},
    '{ROW_ITEM, MODE_INTEG,  4'd0,  REG_EXP_POINT,  32'h0, W_MAX,        1'b0, NONE},
    '{ROW_CFG,  MODE_LOAD,   4'd0,  REG_EXP_POINT,  W_MIN, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, W_MAX,        1'b0, NONE},
    '{ROW_CFG,  MODE_LOAD,   4'd0,  REG_RANGE_LOW,  32'h0, 32'h0,        1'b0, NONE},
    '{ROW_CFG,  MODE_LOAD,   4'd0,  REG_RANGE_HIGH, Q_ONE, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, 32'hffff_ffff, 1'b1, OUT_RANGE},
    '{ROW_ITEM, MODE_INTEG,  4'd0,  REG_EXP_POINT,  32'h0, 32'h0100_0001, 1'b1, OUT_RANGE},
    '{ROW_ITEM, MODE_DERIV,  4'd0,  REG_EXP_POINT,  32'h0, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, Q_ONE,        1'b0, NONE},
    '{ROW_CFG,  MODE_LOAD,   4'd0,  REG_RANGE_LOW,  32'd5, 32'h0,        1'b0, NONE},
    '{ROW_CFG,  MODE_LOAD,   4'd0,  REG_RANGE_HIGH, 32'd4, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_DERIV,  4'd0,  REG_EXP_POINT,  32'h0, 32'd4,        1'b1, OUT_RANGE},
    '{ROW_CFG,  MODE_LOAD,   4'd0,  REG_NONE,       W_MAX, 32'h0,        1'b0, NONE},
    '{ROW_ITEM, MODE_SERIES, 4'd0,  REG_EXP_POINT,  32'h0, 32'd4,        1'b1, OUT_RANGE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // coeff_index[3:0], coeff_value[35:4], x_value[67:36]
  logic [MODE_W-1:0] s_tuser = '0;      // mode[1:0]
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [DATA_W-1:0] m_tdata;           // value[31:0]
  logic [M_TUSER_W-1:0] m_tuser;        // out_of_range[0], saturated[1]
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the block's state
  logic signed [31:0] coef_copy [NCOEF];
  logic signed [31:0] ep_copy;
  logic signed [31:0] lo_copy;
  logic signed [31:0] hi_copy;
  outcome_t pending_evals [$];

  int errors = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int results_seen = 0;
  int oor_seen = 0;
  int sat_seen = 0;
  int holds_done = 0;
  logic sender_gaps = 1'b1;
  logic sink_stalls = 1'b1;
  logic hold_req = 1'b0;

  polynomial_series_evaluator_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [31:0] sat_clip(input longint v, inout logic flag);
    if (v > L_MAX) begin
      flag = 1'b1;
      return W_MAX;
    end
    if (v < L_MIN) begin
      flag = 1'b1;
      return W_MIN;
    end
    return v[31:0];
  endfunction

  // Expected beat for one evaluation at x under the current store and registers
  function automatic outcome_t series_at(input mode_t m, input logic signed [31:0] x);
    longint terms [NCOEF + 1];
    longint acc, p, c, mag, q;
    logic signed [31:0] t;
    logic flag;
    int cnt;
    outcome_t r;
    flag = 1'b0;
    r = '0;
    if (x < lo_copy || x > hi_copy) begin
      r.oor = 1'b1;
      return r;
    end
    t = sat_clip(longint'(x) - longint'(ep_copy), flag);
    case (m)
      MODE_SERIES: begin
        for (int i = 0; i < NCOEF; i++) terms[i] = coef_copy[i];
        cnt = NCOEF;
      end
      MODE_DERIV: begin
        for (int i = 0; i < NCOEF - 1; i++)
          terms[i] = sat_clip(longint'(i + 1) * longint'(coef_copy[i + 1]), flag);
        cnt = NCOEF - 1;
      end
      default: begin
        // integral: divide by power, round half away from zero
        terms[0] = 0;
        for (int i = 1; i <= NCOEF; i++) begin
          c = coef_copy[i - 1];
          mag = (c < 0) ? -c : c;
          q = (mag + longint'(i / 2)) / longint'(i);
          terms[i] = (c < 0) ? -q : q;
        end
        cnt = NCOEF + 1;
      end
    endcase
    acc = terms[cnt - 1];
    for (int k = cnt - 2; k >= 0; k--) begin
      p = acc * longint'(t) + (64'sd1 <<< (FRAC - 1));
      acc = sat_clip((p >>> FRAC) + terms[k], flag);
    end
    r.value = acc[31:0];
    r.sat = flag;
    return r;
  endfunction

  // Random word: mostly near +-2^s, some full range, some extremes
  function automatic logic [31:0] pick_word(input int s);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return W_MAX;
        1: return W_MIN;
        2: return 32'h0;
        3: return 32'hffff_ffff;
        default: return 32'h1;
      endcase
    end
    if (r <= 2) return $urandom;
    return 32'(longint'($urandom_range(0, (1 << (s + 1)) - 1)) - (longint'(1) << s));
  endfunction

  // One input beat; leaves tvalid high after acceptance
  task automatic send_item(input mode_t m, input logic [INDEX_W-1:0] idx,
                           input logic [31:0] cv, input logic [31:0] xv,
                           input logic use_want, input outcome_t want);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, xv, cv, idx};
    s_tuser <= m;
    if (m == MODE_LOAD) begin
      if (idx < NCOEF) coef_copy[idx] = cv;
      loads_sent++;
    end else begin
      pending_evals.push_back(use_want ? want : series_at(m, xv));
    end
    items_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      REG_EXP_POINT: ep_copy = data;
      REG_RANGE_LOW: lo_copy = data;
      REG_RANGE_HIGH: hi_copy = data;
      default: ;
    endcase
  endtask

  task automatic wait_empty();
    while (pending_evals.size() != 0) @(posedge clk);
  endtask

  // Quiet the block before a register write: drain results, then cover a trailing load
  task automatic settle();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    wait_empty();
    repeat (LAT) @(posedge clk);
  endtask

  task automatic configure_phase(input int ph);
    logic [31:0] ep, lo, hi, tmp;
    ep = pick_word(23);
    lo = 32'(-longint'($urandom_range(0, 3 * Q_ONE)));
    hi = $urandom_range(0, 3 * Q_ONE);
    case (ph)
      0: begin
        ep = 32'h0;
        lo = W_MIN;
        hi = W_MAX;
      end
      1: begin
        lo = 32'hfe00_0000;
        hi = 32'h0200_0000;
      end
      2: begin
        ep = W_MAX;
        lo = W_MIN;
        hi = W_MAX;
      end
      3: begin
        ep = W_MIN;
        lo = W_MIN;
        hi = W_MAX;
      end
      default: begin
        // now and then an inverted window
        if ($urandom_range(0, 3) == 0) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
    endcase
    settle();
    write_reg(REG_EXP_POINT, ep);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    mode_t m;
    logic [INDEX_W-1:0] idx;
    if ($urandom_range(0, 9) < 4) m = MODE_LOAD;
    else m = mode_t'($urandom_range(1, 3));
    idx = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(12, 15))
                                      : INDEX_W'($urandom_range(0, 11));
    send_item(m, idx, pick_word(23), pick_word(24), 1'b0, NONE);
  endtask

  // Result sink: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        m_tready <= 1'b1;
        hold_req = 1'b0;
        holds_done++;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser[0]) oor_seen++;
      if (m_tuser[1]) sat_seen++;
      if (pending_evals.size() == 0) begin
        $error("unexpected result beat: value %h, tuser %b", m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_evals.pop_front();
        if (m_tdata !== want.value) begin
          $error("value mismatch: expected %h, got %h", want.value, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want.oor) begin
          $error("out_of_range mismatch: expected %b, got %b", want.oor, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== want.sat) begin
          $error("saturated mismatch: expected %b, got %b", want.sat, m_tuser[1]);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    for (n = 0; n < NCOEF; n++) coef_copy[n] = '0;
    ep_copy = '0;
    lo_copy = W_MIN;
    hi_copy = W_MAX;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < NDIR; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        settle();
        write_reg(DIRECTED[r].sel, DIRECTED[r].a);
      end else begin
        cfg_valid <= 1'b0;
        send_item(DIRECTED[r].mode, DIRECTED[r].idx, DIRECTED[r].a, DIRECTED[r].b,
                  DIRECTED[r].fixed, DIRECTED[r].want);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      configure_phase(ph);
      sender_gaps = (ph != NUM_PHASES - 1) && (ph != 2);
      sink_stalls = (ph != NUM_PHASES - 1) && (ph != 2);
      if (ph == 4) hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender pause until everything is back
        if (ph == 6 && n % 25 == 24 && pending_evals.size() != 0) begin
          s_tvalid <= 1'b0;
          wait_empty();
        end
        random_item();
      end
    end

    // Drain
    s_tvalid <= 1'b0;
    n = 0;
    while (pending_evals.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (LAT) @(posedge clk);
    if (pending_evals.size() != 0) begin
      $error("%0d expected results never arrived", pending_evals.size());
      errors++;
    end

    $display("Covered %0d input beats (%0d loads) over %0d register settings, %0d long hold-offs.",
             items_sent, loads_sent, NUM_PHASES + 4, holds_done);
    $display("Checked %0d result beats: %0d out of range, %0d saturated.",
             results_seen, oor_seen, sat_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
